### rtl/efp_pkg.sv
// ----------------------------------------------------------------------------
// Escape-time fractal pixel: shared package
// Types, widths, command/status groups and fixed-point helper functions used
// by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package efp_pkg;

  localparam int WIDTH        = 1024;
  localparam int HEIGHT       = 1024;
  localparam int PIX_W        = 10;
  localparam int COORD_W      = 13;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 40;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int COUNT_W      = 16;

  localparam int VAL_W        = 40;
  localparam int FRAC         = 28;
  localparam int HALF_W       = 20;

  localparam int PAL_FRAC     = 24;
  localparam int PAL_W        = PAL_FRAC + 1;
  localparam int DIV_STEPS    = PAL_FRAC;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VMAX      = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VMIN      = {1'b1, {(VAL_W-1){1'b0}}};
  localparam val_t LIM_MB    = val_t'(4) <<< FRAC;
  localparam val_t LIM_JULIA = val_t'(32) <<< FRAC;

  localparam logic [PAL_W-1:0] ONE24 = PAL_W'(1) << PAL_FRAC;
  localparam logic [12:0] RED_K   = 13'd2295;
  localparam logic [12:0] GREEN_K = 13'd3825;
  localparam logic [12:0] BLUE_K  = 13'd4335;

  typedef enum logic [1:0] {
    KIND_MANDEL = 2'd0,
    KIND_JULIA  = 2'd1,
    KIND_SHIP   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KIND      = 3'd0,
    REG_ORIGIN_RE = 3'd1,
    REG_ORIGIN_IM = 3'd2,
    REG_STEP_RE   = 3'd3,
    REG_STEP_IM   = 3'd4,
    REG_JULIA_RE  = 3'd5,
    REG_JULIA_IM  = 3'd6,
    REG_MAX_ITER  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic signed [31:0] step_re;
    logic signed [31:0] step_im;
    logic signed [31:0] julia_re;
    logic signed [31:0] julia_im;
    logic [COUNT_W-1:0] max_iter;
  } efp_cfg_t;

  typedef struct packed {
    logic load_in;
    logic map;
    logic cadd;
    logic zinit;
    logic mul;
    logic sum;
    logic pre;
    logic upd;
    logic div_init;
    logic div_step;
    logic pal1;
    logic pal2;
    logic pal3;
    logic load_out;
  } efp_cmd_t;

  typedef struct packed {
    logic run_none;
    logic esc;
    logic zfix;
    logic cnt_last;
    logic out_free;
  } efp_sts_t;

  function automatic val_t sat_wide(input logic signed [VAL_W+2:0] v);
    logic signed [VAL_W+2:0] hi;
    logic signed [VAL_W+2:0] lo;
    hi = (VAL_W+3)'(VMAX);
    lo = (VAL_W+3)'(VMIN);
    if (v > hi) return VMAX;
    if (v < lo) return VMIN;
    return val_t'(v[VAL_W-1:0]);
  endfunction

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic signed [VAL_W+2:0] s;
    s = (VAL_W+3)'(a) + (VAL_W+3)'(b);
    return sat_wide(s);
  endfunction

  function automatic val_t sat_sub(input val_t a, input val_t b);
    logic signed [VAL_W+2:0] s;
    s = (VAL_W+3)'(a) - (VAL_W+3)'(b);
    return sat_wide(s);
  endfunction

  function automatic val_t sat_neg(input val_t a);
    logic signed [VAL_W+2:0] s;
    s = -(VAL_W+3)'(a);
    return sat_wide(s);
  endfunction

  function automatic logic [VAL_W-1:0] mag(input val_t a);
    return a[VAL_W-1] ? (~a + VAL_W'(1)) : a;
  endfunction

  // Combine the four partial products of two magnitudes, drop the fraction
  // bits toward zero, apply the sign and saturate.
  function automatic val_t fmul_fin(input logic [2*HALF_W-1:0] hh,
                                    input logic [2*HALF_W-1:0] hl,
                                    input logic [2*HALF_W-1:0] lh,
                                    input logic [2*HALF_W-1:0] ll,
                                    input logic neg);
    logic [2*HALF_W:0]   mid;
    logic [4*HALF_W-1:0] full;
    logic [4*HALF_W-FRAC-1:0] r;
    logic [4*HALF_W-FRAC-1:0] lim;
    mid  = {1'b0, hl} + {1'b0, lh};
    full = {hh, (2*HALF_W)'(0)} + ((4*HALF_W)'(mid) << HALF_W) + (4*HALF_W)'(ll);
    r    = full[4*HALF_W-1:FRAC];
    lim  = (4*HALF_W-FRAC)'(1) << (VAL_W - 1);
    if (neg) begin
      if (r > lim) return VMIN;
      return val_t'(~r[VAL_W-1:0] + VAL_W'(1));
    end
    if (r >= lim) return VMAX;
    return val_t'(r[VAL_W-1:0]);
  endfunction

  function automatic logic [PAL_W-1:0] qm(input logic [PAL_W-1:0] a,
                                          input logic [PAL_W-1:0] b);
    logic [2*PAL_W-1:0] p;
    p = (2*PAL_W)'(a) * (2*PAL_W)'(b);
    return p[2*PAL_FRAC:PAL_FRAC];
  endfunction

  function automatic logic [7:0] clamp8(input logic [13:0] v);
    return (v > 14'd255) ? 8'hFF : v[7:0];
  endfunction

endpackage

### rtl/efp_ctrl.sv
// ----------------------------------------------------------------------------
// Escape-time fractal pixel: controller
// Sequences mapping, the four-step iteration loop, the serial divider and the
// palette stages, and hands the result to the output register.
// ----------------------------------------------------------------------------
module efp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  efp_pkg::efp_sts_t sts,
  output efp_pkg::efp_cmd_t cmd
);

  typedef enum logic [13:0] {
    ST_IDLE = 14'h0001,
    ST_MAP  = 14'h0002,
    ST_CADD = 14'h0004,
    ST_INIT = 14'h0008,
    ST_MUL  = 14'h0010,
    ST_SUM  = 14'h0020,
    ST_PRE  = 14'h0040,
    ST_UPD  = 14'h0080,
    ST_DIVI = 14'h0100,
    ST_DIVS = 14'h0200,
    ST_PAL1 = 14'h0400,
    ST_PAL2 = 14'h0800,
    ST_PAL3 = 14'h1000,
    ST_OUT  = 14'h2000
  } state_t;

  state_t state;
  state_t state_next;
  logic [efp_pkg::DIV_CNT_W-1:0] div_cnt;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.map    = 1'b1;
        state_next = ST_CADD;
      end
      ST_CADD: begin
        cmd.cadd   = 1'b1;
        state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.zinit  = 1'b1;
        state_next = sts.run_none ? ST_DIVI : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_PRE;
      end
      ST_PRE: begin
        cmd.pre    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        if (sts.esc || sts.zfix || sts.cnt_last) begin
          state_next = ST_DIVI;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_step = 1'b1;
        if (div_cnt == efp_pkg::DIV_CNT_W'(efp_pkg::DIV_STEPS - 1)) begin
          state_next = ST_PAL1;
        end
      end
      ST_PAL1: begin
        cmd.pal1   = 1'b1;
        state_next = ST_PAL2;
      end
      ST_PAL2: begin
        cmd.pal2   = 1'b1;
        state_next = ST_PAL3;
      end
      ST_PAL3: begin
        cmd.pal3   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIVI) begin
        div_cnt <= '0;
      end else if (state == ST_DIVS) begin
        div_cnt <= div_cnt + 1'b1;
      end
    end
  end

endmodule

### rtl/efp_dp.sv
// ----------------------------------------------------------------------------
// Escape-time fractal pixel: datapath
// Coordinate mapping, saturating Q12.28 iteration with a bank of 20x20
// multipliers, a bit-serial divider for the palette position and the
// polynomial palette, ending in the output register.
// ----------------------------------------------------------------------------
module efp_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  efp_pkg::efp_cfg_t                    cfg,
  input  efp_pkg::efp_cmd_t                    cmd,
  output efp_pkg::efp_sts_t                    sts,
  input  logic [efp_pkg::IN_TDATA_W-1:0]       in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [efp_pkg::OUT_TDATA_W-1:0]      out_data
);

  localparam int HW  = efp_pkg::HALF_W;
  localparam int PW  = efp_pkg::PAL_W;
  localparam int CW  = efp_pkg::COUNT_W;

  logic [efp_pkg::PIX_W-1:0] px;
  logic [efp_pkg::PIX_W-1:0] py;
  logic [efp_pkg::PIX_W-1:0] px_c;
  logic [efp_pkg::PIX_W-1:0] py_c;

  logic signed [31:0] org_re, org_im, stp_re, stp_im, jul_re, jul_im;
  logic signed [efp_pkg::VAL_W+2:0] pm_re, pm_im;

  efp_pkg::val_t cre, cim, zr, zi, ar, ai;
  efp_pkg::val_t zr2, zi2, xp, s_sum, d_diff, xd;
  efp_pkg::val_t x_abs, x_dbl, nr, ni, lim;

  logic [efp_pkg::VAL_W-1:0] mag_r, mag_i;
  logic [efp_pkg::VAL_W-1:0] ma [3];
  logic [efp_pkg::VAL_W-1:0] mb [3];
  logic [2*HW-1:0] pp_hh [3];
  logic [2*HW-1:0] pp_hl [3];
  logic [2*HW-1:0] pp_lh [3];
  logic [2*HW-1:0] pp_ll [3];
  logic neg_x;
  logic ship;

  logic [CW-1:0] iters;
  logic [CW:0]   rem;
  logic [CW:0]   rem2;
  logic          qbit;
  logic [PW-1:0] q;
  logic [PW-1:0] u;
  logic [PW-1:0] p_tt, p_uu, p_r, p_g, p_b;

  logic [PW+12:0] c_r, c_g, c_b;
  logic [CW-1:0] out_iters;
  logic [7:0]    out_r, out_g, out_b;

  assign org_re = cfg.origin_re;
  assign org_im = cfg.origin_im;
  assign stp_re = cfg.step_re;
  assign stp_im = cfg.step_im;
  assign jul_re = cfg.julia_re;
  assign jul_im = cfg.julia_im;
  assign ship   = (cfg.kind == efp_pkg::KIND_SHIP);

  assign px_c = ({3'b000, px} >= efp_pkg::COORD_W'(efp_pkg::WIDTH)) ?
                efp_pkg::PIX_W'(efp_pkg::WIDTH - 1) : px;
  assign py_c = ({3'b000, py} >= efp_pkg::COORD_W'(efp_pkg::HEIGHT)) ?
                efp_pkg::PIX_W'(efp_pkg::HEIGHT - 1) : py;

  assign mag_r = efp_pkg::mag(zr);
  assign mag_i = efp_pkg::mag(zi);

  always_comb begin
    ma[0] = mag_r;
    mb[0] = mag_r;
    ma[1] = mag_i;
    mb[1] = mag_i;
    ma[2] = mag_r;
    mb[2] = mag_i;
  end

  always_comb begin
    x_abs = (ship && xp[efp_pkg::VAL_W-1]) ? efp_pkg::sat_neg(xp) : xp;
    x_dbl = efp_pkg::sat_add(x_abs, x_abs);
  end

  assign lim = (cfg.kind == efp_pkg::KIND_JULIA) ? efp_pkg::LIM_JULIA : efp_pkg::LIM_MB;
  assign nr  = efp_pkg::sat_add(d_diff, ar);
  assign ni  = efp_pkg::sat_add(xd, ai);

  assign rem2 = {rem[CW-1:0], 1'b0};
  assign qbit = (cfg.max_iter != '0) && (rem2 >= {1'b0, cfg.max_iter});
  assign u    = efp_pkg::ONE24 - q;

  assign c_r = (PW+13)'(p_r) * (PW+13)'(efp_pkg::RED_K);
  assign c_g = (PW+13)'(p_g) * (PW+13)'(efp_pkg::GREEN_K);
  assign c_b = (PW+13)'(p_b) * (PW+13)'(efp_pkg::BLUE_K);

  always_comb begin
    sts.run_none = (cfg.max_iter == '0) || (cfg.kind == efp_pkg::KIND_NONE);
    sts.esc      = (s_sum >= lim);
    sts.zfix     = (nr == zr) && (ni == zi);
    sts.cnt_last = ({1'b0, iters} + (CW+1)'(1)) == {1'b0, cfg.max_iter};
    sts.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      px <= in_data[efp_pkg::PIX_W-1:0];
      py <= in_data[2*efp_pkg::PIX_W-1:efp_pkg::PIX_W];
    end
    if (cmd.map) begin
      pm_re <= (efp_pkg::VAL_W+3)'(signed'({1'b0, px_c})) * (efp_pkg::VAL_W+3)'(stp_re);
      pm_im <= (efp_pkg::VAL_W+3)'(signed'({1'b0, py_c})) * (efp_pkg::VAL_W+3)'(stp_im);
    end
    if (cmd.cadd) begin
      cre <= efp_pkg::sat_add(efp_pkg::sat_wide(pm_re), efp_pkg::val_t'(org_re));
      cim <= efp_pkg::sat_add(efp_pkg::sat_wide(pm_im), efp_pkg::val_t'(org_im));
    end
    if (cmd.zinit) begin
      iters <= '0;
      if (cfg.kind == efp_pkg::KIND_JULIA) begin
        zr <= efp_pkg::sat_add(efp_pkg::val_t'(jul_re), cre);
        zi <= efp_pkg::sat_add(efp_pkg::val_t'(jul_im), cim);
        ar <= efp_pkg::val_t'(jul_re);
        ai <= efp_pkg::val_t'(jul_im);
      end else begin
        zr <= '0;
        zi <= '0;
        ar <= cre;
        ai <= cim;
      end
    end
    if (cmd.mul) begin
      for (int k = 0; k < 3; k++) begin
        pp_hh[k] <= (2*HW)'(ma[k][2*HW-1:HW]) * (2*HW)'(mb[k][2*HW-1:HW]);
        pp_hl[k] <= (2*HW)'(ma[k][2*HW-1:HW]) * (2*HW)'(mb[k][HW-1:0]);
        pp_lh[k] <= (2*HW)'(ma[k][HW-1:0]) * (2*HW)'(mb[k][2*HW-1:HW]);
        pp_ll[k] <= (2*HW)'(ma[k][HW-1:0]) * (2*HW)'(mb[k][HW-1:0]);
      end
      neg_x <= zr[efp_pkg::VAL_W-1] ^ zi[efp_pkg::VAL_W-1];
    end
    if (cmd.sum) begin
      zr2 <= efp_pkg::fmul_fin(pp_hh[0], pp_hl[0], pp_lh[0], pp_ll[0], 1'b0);
      zi2 <= efp_pkg::fmul_fin(pp_hh[1], pp_hl[1], pp_lh[1], pp_ll[1], 1'b0);
      xp  <= efp_pkg::fmul_fin(pp_hh[2], pp_hl[2], pp_lh[2], pp_ll[2], neg_x);
    end
    if (cmd.pre) begin
      s_sum  <= efp_pkg::sat_add(zr2, zi2);
      d_diff <= efp_pkg::sat_sub(zr2, zi2);
      xd     <= ship ? -x_dbl : x_dbl;
    end
    if (cmd.upd && !sts.esc) begin
      if (sts.zfix) begin
        iters <= cfg.max_iter;
      end else begin
        zr    <= nr;
        zi    <= ni;
        iters <= iters + 1'b1;
      end
    end
    if (cmd.div_init) begin
      if ((cfg.max_iter != '0) && (iters >= cfg.max_iter)) begin
        rem <= {1'b0, iters - cfg.max_iter};
        q   <= PW'(1);
      end else begin
        rem <= {1'b0, iters};
        q   <= '0;
      end
    end
    if (cmd.div_step) begin
      rem <= qbit ? (rem2 - {1'b0, cfg.max_iter}) : rem2;
      q   <= {q[PW-2:0], qbit};
    end
    if (cmd.pal1) begin
      p_tt <= efp_pkg::qm(q, q);
      p_uu <= efp_pkg::qm(u, u);
    end
    if (cmd.pal2) begin
      p_r <= efp_pkg::qm(p_tt, q);
      p_g <= efp_pkg::qm(p_tt, u);
      p_b <= efp_pkg::qm(p_uu, u);
    end
    if (cmd.pal3) begin
      p_r <= efp_pkg::qm(p_r, u);
      p_g <= efp_pkg::qm(p_g, u);
      p_b <= efp_pkg::qm(p_b, q);
    end
    if (cmd.load_out) begin
      out_iters <= iters;
      out_r     <= efp_pkg::clamp8(c_r[PW+12:efp_pkg::PAL_FRAC]);
      out_g     <= efp_pkg::clamp8(c_g[PW+12:efp_pkg::PAL_FRAC]);
      out_b     <= efp_pkg::clamp8({1'b0, c_b[PW+12:efp_pkg::PAL_FRAC+1]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data = {out_b, out_g, out_r, out_iters};

endmodule

### rtl/escape_time_fractal_pixel.sv
// ----------------------------------------------------------------------------
// Escape-time fractal pixel
// Maps a pixel index to a complex point, runs a Mandelbrot, Julia or Burning
// Ship escape-time iteration on it and colors the count with a palette.
//
//   Channel  Direction  Contents
//   s_axis   in         pixel coordinate (pixel_x, pixel_y)
//   m_axis   out        iteration count and red, green, blue
//   cfg      in         register writes, one per cycle
//
// Each pixel goes through mapping, the iteration loop (one pass for every
// iteration, the pass that finds the escape included), the 24-step serial
// divider and the palette. Each pass updates z through the multiplier bank
// in the states multiply, sum, pre-add and update.
// Reset is synchronous and restores the register defaults.
// A new pixel is taken once the previous result sits in the output register;
// a stalled output holds the next result back in the controller.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pixel_x, pixel_y, zero fill
  input  logic [efp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // iteration_count, red, green, blue
  output logic [efp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [efp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [efp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  efp_pkg::efp_cfg_t cfg;
  efp_pkg::efp_cmd_t cmd;
  efp_pkg::efp_sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind      <= efp_pkg::KIND_MANDEL;
      cfg.origin_re <= -32'sd536870912;
      cfg.origin_im <= -32'sd536870912;
      cfg.step_re   <= 32'sd1048576;
      cfg.step_im   <= 32'sd1048576;
      cfg.julia_re  <= '0;
      cfg.julia_im  <= '0;
      cfg.max_iter  <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        efp_pkg::REG_KIND:      cfg.kind      <= efp_pkg::kind_t'(cfg_data[1:0]);
        efp_pkg::REG_ORIGIN_RE: cfg.origin_re <= cfg_data;
        efp_pkg::REG_ORIGIN_IM: cfg.origin_im <= cfg_data;
        efp_pkg::REG_STEP_RE:   cfg.step_re   <= cfg_data;
        efp_pkg::REG_STEP_IM:   cfg.step_im   <= cfg_data;
        efp_pkg::REG_JULIA_RE:  cfg.julia_re  <= cfg_data;
        efp_pkg::REG_JULIA_IM:  cfg.julia_im  <= cfg_data;
        efp_pkg::REG_MAX_ITER:  cfg.max_iter  <= cfg_data[efp_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  efp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  efp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the escape-time fractal pixel unit
// Pixel coordinates go in on the slave stream, and each transfer is scored
// against a predictor of the mapping, the escape-time iteration and the
// palette. Predictions wait in order until the matching result leaves the
// master stream. Directed views cover reset defaults, every fractal kind, the
// iteration limits and saturated mapping. Random views follow, with bursts
// of idling on both streams and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] count;
  } pixel_color_t;

  localparam longint      V_HI         = 64'sd549755813887;
  localparam longint      V_LO         = -V_HI - 1;
  localparam logic [79:0] MAG_POS_LIM  = 80'd549755813887;
  localparam logic [79:0] MAG_NEG_LIM  = 80'd549755813888;
  localparam logic [31:0] ORIGIN_DEF   = 32'hE000_0000;
  localparam logic [31:0] STEP_DEF     = 32'h0010_0000;
  localparam logic [31:0] FIX_POS_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] FIX_NEG_MAX  = 32'h8000_0000;
  localparam int          CYCLE_LIMIT  = 3_000_000;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [efp_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [efp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_we;
  logic [efp_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [efp_pkg::CFG_DATA_W-1:0]  cfg_data;

  efp_pkg::efp_cfg_t view_regs;
  pixel_color_t      expected_colors[$];
  pixel_color_t      seen_color;
  pixel_color_t      want_color;
  int                mismatches = 0;
  int                results_seen = 0;
  int                cycles = 0;
  bit                src_idle = 1'b1;
  bit                sink_idle = 1'b1;

  escape_time_fractal_pixel DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clip40(input longint v);
    if (v > V_HI) return V_HI;
    if (v < V_LO) return V_LO;
    return v;
  endfunction

  // Fixed-point product: exact magnitude product truncated toward zero.
  function automatic longint qmul(input longint a, input longint b);
    logic [79:0] ma;
    logic [79:0] mb;
    logic [79:0] r;
    bit          neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? 80'(-a) : 80'(a);
    mb  = (b < 0) ? 80'(-b) : 80'(b);
    r   = (ma * mb) >> efp_pkg::FRAC;
    if (neg) begin
      if (r > MAG_NEG_LIM) return V_LO;
      return -longint'(r[63:0]);
    end
    if (r > MAG_POS_LIM) return V_HI;
    return longint'(r[63:0]);
  endfunction

  function automatic u64_t pmul(input u64_t a, input u64_t b);
    return (a * b) >> 24;
  endfunction

  function automatic logic [7:0] sat8(input u64_t v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic pixel_color_t render_pixel(input logic [9:0] px, input logic [9:0] py);
    pixel_color_t res;
    int unsigned  xi;
    int unsigned  yi;
    int unsigned  n;
    int unsigned  maxit;
    longint       cre;
    longint       cim;
    longint       zr;
    longint       zi;
    longint       ar;
    longint       ai;
    longint       zr2;
    longint       zi2;
    longint       xy;
    longint       nr;
    longint       ni;
    longint       lim;
    u64_t         t;
    u64_t         u;
    bit           ship;
    res = '0;
    if (view_regs.kind == efp_pkg::KIND_NONE) return res;
    xi = px;
    yi = py;
    if (xi >= efp_pkg::WIDTH) xi = efp_pkg::WIDTH - 1;
    if (yi >= efp_pkg::HEIGHT) yi = efp_pkg::HEIGHT - 1;
    cre = clip40(clip40(longint'(xi) * longint'($signed(view_regs.step_re)))
                 + longint'($signed(view_regs.origin_re)));
    cim = clip40(clip40(longint'(yi) * longint'($signed(view_regs.step_im)))
                 + longint'($signed(view_regs.origin_im)));
    ship  = view_regs.kind == efp_pkg::KIND_SHIP;
    maxit = view_regs.max_iter;
    if (view_regs.kind == efp_pkg::KIND_JULIA) begin
      ar  = longint'($signed(view_regs.julia_re));
      ai  = longint'($signed(view_regs.julia_im));
      zr  = clip40(ar + cre);
      zi  = clip40(ai + cim);
      lim = longint'(32) << efp_pkg::FRAC;
    end else begin
      ar  = cre;
      ai  = cim;
      zr  = 0;
      zi  = 0;
      lim = longint'(4) << efp_pkg::FRAC;
    end
    n = 0;
    while (n < maxit) begin
      zr2 = qmul(zr, zr);
      zi2 = qmul(zi, zi);
      if (clip40(zr2 + zi2) >= lim) break;
      nr = clip40(clip40(zr2 - zi2) + ar);
      xy = qmul(zr, zi);
      if (ship && xy < 0) xy = clip40(-xy);
      xy = clip40(xy + xy);
      if (ship) xy = -xy;
      ni = clip40(xy + ai);
      if (nr == zr && ni == zi) begin
        n = maxit;
        break;
      end
      zr = nr;
      zi = ni;
      n++;
    end
    t = (maxit == 0) ? 0 : ((u64_t'(n) << 24) / u64_t'(maxit));
    u = (u64_t'(1) << 24) - t;
    res.count = n[15:0];
    res.red   = sat8((pmul(pmul(pmul(t, t), t), u) * 2295) >> 24);
    res.green = sat8((pmul(pmul(pmul(t, t), u), u) * 3825) >> 24);
    res.blue  = sat8((pmul(pmul(pmul(u, u), u), t) * 4335) >> 25);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  task automatic write_reg(input efp_pkg::cfg_reg_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      efp_pkg::REG_KIND:      view_regs.kind      = efp_pkg::kind_t'(value[1:0]);
      efp_pkg::REG_ORIGIN_RE: view_regs.origin_re = value;
      efp_pkg::REG_ORIGIN_IM: view_regs.origin_im = value;
      efp_pkg::REG_STEP_RE:   view_regs.step_re   = value;
      efp_pkg::REG_STEP_IM:   view_regs.step_im   = value;
      efp_pkg::REG_JULIA_RE:  view_regs.julia_re  = value;
      efp_pkg::REG_JULIA_IM:  view_regs.julia_im  = value;
      efp_pkg::REG_MAX_ITER:  view_regs.max_iter  = value[15:0];
      default: ;
    endcase
  endtask

  task automatic program_view(input efp_pkg::kind_t kind, input logic [31:0] ore,
                              input logic [31:0] oim,
                              input logic [31:0] sre, input logic [31:0] sim,
                              input logic [31:0] jre, input logic [31:0] jim,
                              input logic [15:0] maxit);
    write_reg(efp_pkg::REG_KIND, 32'(kind));
    write_reg(efp_pkg::REG_ORIGIN_RE, ore);
    write_reg(efp_pkg::REG_ORIGIN_IM, oim);
    write_reg(efp_pkg::REG_STEP_RE, sre);
    write_reg(efp_pkg::REG_STEP_IM, sim);
    write_reg(efp_pkg::REG_JULIA_RE, jre);
    write_reg(efp_pkg::REG_JULIA_IM, jim);
    write_reg(efp_pkg::REG_MAX_ITER, 32'(maxit));
  endtask

  task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
    int gap;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, py, px};
    do @(posedge clk); while (!s_axis_tready);
    expected_colors.push_back(render_pixel(px, py));
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
  endtask

  // Registers are only rewritten once every result is back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_view(input int lim_lo, input int lim_hi);
    efp_pkg::kind_t kind;
    logic [31:0]    ore;
    logic [31:0]    oim;
    logic [31:0]    sre;
    logic [31:0]    sim;
    logic [31:0]    jre;
    logic [31:0]    jim;
    logic [15:0]    maxit;
    kind = ($urandom_range(0, 11) == 0) ? efp_pkg::KIND_NONE
           : efp_pkg::kind_t'($urandom_range(efp_pkg::KIND_MANDEL, efp_pkg::KIND_SHIP));
    if ($urandom_range(0, 4) == 0) begin
      ore = $urandom();
      oim = $urandom();
      sre = $urandom();
      sim = $urandom();
      jre = $urandom();
      jim = $urandom();
    end else begin
      ore = $urandom_range(0, 805306368) - 32'd671088640;
      oim = $urandom_range(0, 805306368) - 32'd402653184;
      sre = $urandom_range(0, 1 << 20);
      sim = $urandom_range(0, 1 << 20);
      if ($urandom_range(0, 3) == 0) sre = -sre;
      if ($urandom_range(0, 3) == 0) sim = -sim;
      jre = $urandom_range(0, 1 << 29) - 32'd268435456;
      jim = $urandom_range(0, 1 << 29) - 32'd268435456;
    end
    if ($urandom_range(0, 19) == 0) maxit = 16'($urandom_range(0, 2));
    else maxit = 16'($urandom_range(lim_lo, lim_hi));
    program_view(kind, ore, oim, sre, sim, jre, jim, maxit);
  endtask

  task automatic test_default_view();
    drain_results();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd512);
    send_pixel(10'd384, 10'd512);
  endtask

  task automatic test_fractal_kinds();
    drain_results();
    program_view(efp_pkg::KIND_JULIA, ORIGIN_DEF, ORIGIN_DEF, STEP_DEF, STEP_DEF,
                 32'hF333_3333, 32'h027E_FA4B, 16'd64);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd600, 10'd420);
    send_pixel(10'd1023, 10'd0);
    drain_results();
    program_view(efp_pkg::KIND_SHIP, ORIGIN_DEF, ORIGIN_DEF, STEP_DEF, STEP_DEF,
                 32'd0, 32'd0, 16'd64);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd300, 10'd600);
    send_pixel(10'd1023, 10'd1023);
    drain_results();
    write_reg(efp_pkg::REG_KIND, 32'(efp_pkg::KIND_NONE));
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
  endtask

  task automatic test_iteration_limits();
    drain_results();
    program_view(efp_pkg::KIND_MANDEL, ORIGIN_DEF, ORIGIN_DEF, STEP_DEF, STEP_DEF,
                 32'd0, 32'd0, 16'd0);
    send_pixel(10'd384, 10'd512);
    send_pixel(10'd1023, 10'd0);
    drain_results();
    write_reg(efp_pkg::REG_MAX_ITER, 32'd1);
    send_pixel(10'd512, 10'd512);
    drain_results();
    write_reg(efp_pkg::REG_MAX_ITER, 32'd65535);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);
  endtask

  task automatic test_saturated_mapping();
    drain_results();
    program_view(efp_pkg::KIND_MANDEL, FIX_POS_MAX, FIX_NEG_MAX, FIX_POS_MAX, FIX_NEG_MAX,
                 32'd0, 32'd0, 16'd16);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    drain_results();
    program_view(efp_pkg::KIND_JULIA, FIX_NEG_MAX, FIX_POS_MAX, FIX_NEG_MAX, FIX_POS_MAX,
                 FIX_POS_MAX, FIX_NEG_MAX, 16'd16);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1, 10'd2);
  endtask

  task automatic test_random_views();
    repeat (28) begin
      drain_results();
      random_view(1, 48);
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      send_random_pixels($urandom_range(30, 60));
    end
  endtask

  task automatic test_long_orbits();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (2) begin
      drain_results();
      random_view(200, 256);
      send_random_pixels(20);
    end
  endtask

  task automatic test_back_to_back();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (4) begin
      drain_results();
      random_view(1, 48);
      send_random_pixels(40);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_color = pixel_color_t'(m_axis_tdata);
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("result %h with no pixel waiting", m_axis_tdata));
      end else begin
        want_color = expected_colors.pop_front();
        compare_field("iteration_count", seen_color.count, want_color.count);
        compare_field("red", seen_color.red, want_color.red);
        compare_field("green", seen_color.green, want_color.green);
        compare_field("blue", seen_color.blue, want_color.blue);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int hold;
    m_axis_tready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 13);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    view_regs.kind      = efp_pkg::KIND_MANDEL;
    view_regs.origin_re = ORIGIN_DEF;
    view_regs.origin_im = ORIGIN_DEF;
    view_regs.step_re   = STEP_DEF;
    view_regs.step_im   = STEP_DEF;
    view_regs.julia_re  = '0;
    view_regs.julia_im  = '0;
    view_regs.max_iter  = 16'd256;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_view();
    test_fractal_kinds();
    test_iteration_limits();
    test_saturated_mapping();
    test_random_views();
    test_long_orbits();
    test_back_to_back();
    drain_results();
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
